// File: rtl/fba_pkg.sv
package fba_pkg;

   localparam int MAX_SAMPLES     = 16;
   localparam int SEEN_BITS       = $clog2(MAX_SAMPLES + 1);
   localparam int COORD_FRAC_BITS = 4;
   localparam int STEP_BITS       = 5;
   localparam logic [STEP_BITS-1:0] RATIO_STEPS = 5'd16;
   localparam logic [STEP_BITS-1:0] MEAN_STEPS  = 5'd8;
   localparam logic [1:0] CH_LAST = 2'd2;
   localparam logic [7:0] COLOR_MAX = 8'hFF;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] sample_col;
      logic [15:0] sample_row;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        sample_ok;
      logic        last_sample;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       covered;
   } rsp_word_type;

   typedef struct packed {
      logic                 start;
      logic [23:0]          rem;
      logic [23:0]          div;
      logic [15:0]          bits;
      logic [STEP_BITS-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [15:0] quot;
   } div_stat_type;

   // min(ratio, ONE - ratio) for a ratio below ONE
   function automatic logic [15:0] axis_weight(input logic [15:0] ratio);
      logic [15:0] mirror;
      mirror = 16'(17'h10000 - {1'b0, ratio});
      return ratio[15] ? mirror : ratio;
   endfunction

endpackage

// File: rtl/fba_divider.sv
module fba_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  fba_pkg::div_cmd_type div_cmd,
   output fba_pkg::div_stat_type div_stat
);
   import fba_pkg::*;

   logic [23:0]          rem_ff, rem_in;
   logic [23:0]          div_ff;
   logic [15:0]          bits_ff;
   logic [15:0]          quot_ff;
   logic [STEP_BITS-1:0] count_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [24:0]          trial;
   logic [24:0]          diff;
   logic                 fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, bits_ff[15]};
      diff   = trial - {1'b0, div_ff};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? diff[23:0] : trial[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_cmd.start) begin
            busy_ff  <= 1'b1;
            count_ff <= div_cmd.steps;
            rem_ff   <= div_cmd.rem;
            div_ff   <= div_cmd.div;
            bits_ff  <= div_cmd.bits;
            quot_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            bits_ff  <= {bits_ff[14:0], 1'b0};
            quot_ff  <= {quot_ff[14:0], fits};
            count_ff <= count_ff - 1'b1;
            if (count_ff == STEP_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign div_stat.quot = quot_ff;

endmodule

// File: rtl/feather_blend_accumulator.sv
// channel  | ports                              | direction
// ---------+------------------------------------+----------
// request  | req_valid, req_stall, req_word     | in
// response | rsp_valid, rsp_stall, rsp_word     | out
// config   | csr_write_enable, csr_write_data   | in
//
// Counted word: req_stall is held, in both-directions mode, for a column and a row
// ratio division (each skipped when its axis is out of range), a serial multiply of
// the two weights, then color multiply and accumulate; column-only mode skips the row
// division and the multiply. A skipped word stalls nothing. A last word adds a mean
// division per channel (none if it saturates) and an emit state waiting on rsp_stall.
// Reset is synchronous; the next request is taken while a response waits.
module feather_blend_accumulator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fba_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fba_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);
   import fba_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_COL_GO, S_COL_WAIT, S_ROW_GO, S_ROW_WAIT, S_MUL,
      S_COLOR_GO, S_COLOR, S_ACC, S_MEAN_GO, S_MEAN_WAIT, S_EMIT
   } state_type;

   state_type            state_ff;
   req_word_type         item_ff;
   rsp_word_type         rsp_word_ff;
   logic                 rsp_valid_ff;
   logic                 mode_ff;
   logic [SEEN_BITS-1:0] seen_ff;
   logic [STEP_BITS-1:0] cnt_ff;
   logic [15:0]          wc_ff, wr_ff, w_ff;
   logic [31:0]          mul_ff;
   logic [7:0]           col_ff  [3];
   logic [23:0]          prod_ff [3];
   logic [31:0]          sum_ff  [3];
   logic [7:0]           res_ff  [3];
   logic [23:0]          wsum_ff;
   logic [1:0]           ch_ff;
   logic                 covered_ff;

   div_cmd_type  div_cmd;
   div_stat_type div_stat;

   logic [16:0] col_den, row_den;
   logic        col_in, row_in;
   logic [31:0] sum_sel;
   logic        mean_sat;
   logic [16:0] mul_sum;
   logic [16:0] lane_sum [3];
   logic [32:0] acc_sum  [3];
   logic [24:0] wsum_add;
   logic        can_emit;

   fba_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_stat(div_stat)
   );

   always_comb begin
      col_den  = {item_ff.image_width, {COORD_FRAC_BITS{1'b0}}};
      row_den  = {item_ff.image_height, {COORD_FRAC_BITS{1'b0}}};
      col_in   = (col_den != '0) && ({1'b0, item_ff.sample_col} < col_den);
      row_in   = (row_den != '0) && ({1'b0, item_ff.sample_row} < row_den);
      sum_sel  = sum_ff[ch_ff];
      mean_sat = sum_sel >= {wsum_ff, 8'h00};
      mul_sum  = {1'b0, mul_ff[31:16]} + (wr_ff[0] ? {1'b0, wc_ff} : 17'd0);
      for (int i = 0; i < 3; i++) begin
         lane_sum[i] = {1'b0, prod_ff[i][23:8]} + (col_ff[i][0] ? {1'b0, w_ff} : 17'd0);
         acc_sum[i]  = {1'b0, sum_ff[i]} + {9'd0, prod_ff[i]};
      end
      wsum_add = {1'b0, wsum_ff} + {9'd0, w_ff};
      can_emit = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      div_cmd = '0;
      unique case (state_ff)
         S_COL_GO: begin
            div_cmd.start = col_in;
            div_cmd.rem   = {8'd0, item_ff.sample_col};
            div_cmd.div   = {7'd0, col_den};
            div_cmd.steps = RATIO_STEPS;
         end
         S_ROW_GO: begin
            div_cmd.start = row_in;
            div_cmd.rem   = {8'd0, item_ff.sample_row};
            div_cmd.div   = {7'd0, row_den};
            div_cmd.steps = RATIO_STEPS;
         end
         S_MEAN_GO: begin
            div_cmd.start = (wsum_ff != '0) && !mean_sat;
            div_cmd.rem   = sum_sel[31:8];
            div_cmd.div   = wsum_ff;
            div_cmd.bits  = {sum_sel[7:0], 8'h00};
            div_cmd.steps = MEAN_STEPS;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         wsum_ff      <= '0;
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_word;
                  ch_ff   <= '0;
                  if (seen_ff < SEEN_BITS'(MAX_SAMPLES)) begin
                     seen_ff <= seen_ff + 1'b1;
                  end
                  if (req_word.sample_ok && (seen_ff < SEEN_BITS'(MAX_SAMPLES))) begin
                     state_ff <= S_COL_GO;
                  end else if (req_word.last_sample) begin
                     state_ff <= S_MEAN_GO;
                  end
               end
            end
            S_COL_GO: begin
               wc_ff    <= '0;
               w_ff     <= '0;
               if (col_in) begin
                  state_ff <= S_COL_WAIT;
               end else if (mode_ff) begin
                  state_ff <= S_COLOR_GO;
               end else begin
                  state_ff <= S_ROW_GO;
               end
            end
            S_COL_WAIT: begin
               if (div_stat.done) begin
                  wc_ff    <= axis_weight(div_stat.quot);
                  w_ff     <= axis_weight(div_stat.quot);
                  state_ff <= mode_ff ? S_COLOR_GO : S_ROW_GO;
               end
            end
            S_ROW_GO: begin
               wr_ff    <= '0;
               mul_ff   <= '0;
               cnt_ff   <= RATIO_STEPS;
               state_ff <= row_in ? S_ROW_WAIT : S_MUL;
            end
            S_ROW_WAIT: begin
               if (div_stat.done) begin
                  wr_ff    <= axis_weight(div_stat.quot);
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               mul_ff <= {mul_sum, mul_ff[15:1]};
               wr_ff  <= {1'b0, wr_ff[15:1]};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == STEP_BITS'(1)) begin
                  w_ff     <= mul_sum[16:1];
                  state_ff <= S_COLOR_GO;
               end
            end
            S_COLOR_GO: begin
               col_ff[0] <= item_ff.red;
               col_ff[1] <= item_ff.green;
               col_ff[2] <= item_ff.blue;
               for (int i = 0; i < 3; i++) prod_ff[i] <= '0;
               cnt_ff    <= MEAN_STEPS;
               state_ff  <= S_COLOR;
            end
            S_COLOR: begin
               for (int i = 0; i < 3; i++) begin
                  prod_ff[i] <= {lane_sum[i], prod_ff[i][7:1]};
                  col_ff[i]  <= {1'b0, col_ff[i][7:1]};
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == STEP_BITS'(1)) begin
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               for (int i = 0; i < 3; i++) begin
                  sum_ff[i] <= acc_sum[i][32] ? '1 : acc_sum[i][31:0];
               end
               wsum_ff  <= wsum_add[24] ? '1 : wsum_add[23:0];
               state_ff <= item_ff.last_sample ? S_MEAN_GO : S_IDLE;
            end
            S_MEAN_GO: begin
               if (wsum_ff == '0) begin
                  for (int i = 0; i < 3; i++) res_ff[i] <= '0;
                  covered_ff <= 1'b0;
                  state_ff   <= S_EMIT;
               end else begin
                  covered_ff <= 1'b1;
                  if (mean_sat) begin
                     res_ff[ch_ff] <= COLOR_MAX;
                     ch_ff         <= ch_ff + 1'b1;
                     if (ch_ff == CH_LAST) begin
                        state_ff <= S_EMIT;
                     end
                  end else begin
                     state_ff <= S_MEAN_WAIT;
                  end
               end
            end
            S_MEAN_WAIT: begin
               if (div_stat.done) begin
                  res_ff[ch_ff] <= div_stat.quot[7:0];
                  ch_ff         <= ch_ff + 1'b1;
                  state_ff      <= (ch_ff == CH_LAST) ? S_EMIT : S_MEAN_GO;
               end
            end
            S_EMIT: begin
               if (can_emit) begin
                  rsp_word_ff.out_red   <= res_ff[0];
                  rsp_word_ff.out_green <= res_ff[1];
                  rsp_word_ff.out_blue  <= res_ff[2];
                  rsp_word_ff.covered   <= covered_ff;
                  rsp_valid_ff          <= 1'b1;
                  seen_ff               <= '0;
                  wsum_ff               <= '0;
                  for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_BITS'(MAX_SAMPLES))
      else $error("sample count beyond limit");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_COL_WAIT || state_ff == S_ROW_WAIT ||
                         state_ff == S_MEAN_WAIT))
      else $error("divider result with nobody waiting");

   a_black_uncovered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.covered) |->
         (rsp_word_ff.out_red == 8'h00 && rsp_word_ff.out_green == 8'h00 &&
          rsp_word_ff.out_blue == 8'h00))
      else $error("uncovered pixel not black");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && can_emit) |=> (wsum_ff == '0 && seen_ff == '0))
      else $error("accumulators not cleared after pixel");

endmodule
